@@ hdl/bls_pkg.sv @@
// shared types and codes for the bounded lifo stack unit
package bls_pkg;

   // word width of one stack entry
   localparam int unsigned WORD_W = 32;

   // request operation codes
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;
   localparam logic [1:0] OP_SEARCH = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   // packed response widths
   localparam int unsigned RSP_BITS = 41;
   localparam int unsigned RSP_TDATA_W = 48;

   // controls broadcast to every cell of the chain
   typedef struct packed {
      logic shift_down;   // push: every word moves one cell deeper
      logic shift_up;     // pop: every word moves one cell toward the top
      logic load_match;   // capture the compare result against the key
   } cell_ctrl_type;

   // one response transaction
   typedef struct packed {
      logic        full_res;
      logic        empty_res;
      logic [3:0]  level;
      logic        found;
      logic signed [WORD_W-1:0] data;
      logic [1:0]  status;
   } rsp_type;

endpackage

@@ hdl/bls_cell.sv @@
// one cell of the stack chain: a word, an occupied flag and a match flag
module bls_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  bls_pkg::cell_ctrl_type         ctrl,
   input  logic signed [bls_pkg::WORD_W-1:0] key,
   input  logic signed [bls_pkg::WORD_W-1:0] above_word,
   input  logic                           above_occ,
   input  logic signed [bls_pkg::WORD_W-1:0] below_word,
   input  logic                           below_occ,
   output logic signed [bls_pkg::WORD_W-1:0] word,
   output logic                           occ,
   output logic                           match
);

   logic signed [bls_pkg::WORD_W-1:0] word_ff, word_in;
   logic occ_ff, occ_in;
   logic match_ff, match_in;

   // neighbor handoff on push and pop
   always_comb begin
      word_in = word_ff;
      occ_in  = occ_ff;
      if (ctrl.shift_down) begin
         word_in = above_word;
         occ_in  = above_occ;
      end else if (ctrl.shift_up) begin
         word_in = below_word;
         occ_in  = below_occ;
      end
   end

   // local compare against the search key
   always_comb begin
      match_in = match_ff;
      if (ctrl.load_match) begin
         match_in = occ_ff && (word_ff == key);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign word  = word_ff;
   assign occ   = occ_ff;
   assign match = match_ff;

endmodule

@@ hdl/bounded_lifo_stack_unit.sv @@
// top level of the bounded lifo stack: cell chain, fill count and response queue
//
// channel   dir  tdata                                  tuser
// req_      in   [31:0] value                           [1:0] operation
// rsp_      out  [1:0] status, [33:2] data, [34] found, -
//                [38:35] level, [39] empty_res, [40] full_res
//
// push, pop and peek put their response into the queue as they are accepted; search
// first registers a compare in every cell, then an or over the match flags of the chain
// gives its response, so at most one transaction per cycle while requests are not stalled.
// reset clears the fill count, the occupied flags and the response queue.
// a two-entry response queue lets requests keep flowing while a response waits;
// requests stall only when both entries are taken or a search is in flight.
module bounded_lifo_stack_unit #(
   parameter int unsigned DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [bls_pkg::RSP_TDATA_W-1:0] rsp_tdata  // status, data, found, level,
                                                      // empty_res, full_res
);

   localparam int unsigned LVL_W = $clog2(DEPTH + 1);
   localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(DEPTH);
   localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_SEARCH = 1'b1;

   logic state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   logic accept;
   logic [1:0] op;
   logic signed [bls_pkg::WORD_W-1:0] value;

   bls_pkg::cell_ctrl_type ctrl;
   logic signed [bls_pkg::WORD_W-1:0] cell_word [DEPTH];
   logic [DEPTH-1:0] cell_occ;
   logic [DEPTH-1:0] cell_match;

   logic res_valid;
   bls_pkg::rsp_type res;
   logic [LVL_W+3:0] lvl_ext;

   bls_pkg::rsp_type q_ff [2];
   bls_pkg::rsp_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic q_pop;
   logic [1:0] cnt_after_pop;

   assign op     = req_tuser;
   assign value  = req_tdata;
   assign req_tready = (state_ff == S_IDLE) && (cnt_ff != 2'd2);
   assign accept = req_tvalid && req_tready;

   // chain controls
   always_comb begin
      ctrl.shift_down = accept && (op == bls_pkg::OP_PUSH) && (lvl_ff != LVL_MAX);
      ctrl.shift_up   = accept && (op == bls_pkg::OP_POP) && (lvl_ff != '0);
      ctrl.load_match = accept && (op == bls_pkg::OP_SEARCH);
   end

   // the chain: cell zero holds the top of the stack
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [bls_pkg::WORD_W-1:0] above_word, below_word;
      logic above_occ, below_occ;
      if (i == 0) begin : g_top
         assign above_word = value;
         assign above_occ  = 1'b1;
      end else begin : g_mid
         assign above_word = cell_word[i-1];
         assign above_occ  = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_bot
         assign below_word = cell_word[i];
         assign below_occ  = 1'b0;
      end else begin : g_inner
         assign below_word = cell_word[i+1];
         assign below_occ  = cell_occ[i+1];
      end
      bls_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (value),
         .above_word (above_word),
         .above_occ  (above_occ),
         .below_word (below_word),
         .below_occ  (below_occ),
         .word       (cell_word[i]),
         .occ        (cell_occ[i]),
         .match      (cell_match[i])
      );
   end

   // sequencing and fill count
   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.load_match) begin
               state_in = S_SEARCH;
            end
            if (ctrl.shift_down) begin
               lvl_in = lvl_ff + LVL_ONE;
            end else if (ctrl.shift_up) begin
               lvl_in = lvl_ff - LVL_ONE;
            end
         end
         S_SEARCH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   // response built from the operation and the level after it
   assign lvl_ext = {4'b0000, lvl_in};
   always_comb begin
      res.status    = bls_pkg::ST_OK;
      res.data      = '0;
      res.found     = 1'b0;
      res.level     = lvl_ext[3:0];
      res.empty_res = (lvl_in == '0);
      res.full_res  = (lvl_in == LVL_MAX);
      res_valid     = 1'b0;
      if (state_ff == S_SEARCH) begin
         res_valid = 1'b1;
         res.found = |cell_match;
      end else if (accept) begin
         case (op)
            bls_pkg::OP_PUSH: begin
               res_valid = 1'b1;
               if (lvl_ff == LVL_MAX) begin
                  res.status = bls_pkg::ST_OVERFLOW;
               end
            end
            bls_pkg::OP_POP, bls_pkg::OP_PEEK: begin
               res_valid = 1'b1;
               if (lvl_ff == '0) begin
                  res.status = bls_pkg::ST_UNDERFLOW;
               end else begin
                  res.data = cell_word[0];
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // two-entry response queue, head in entry zero
   assign q_pop = rsp_tvalid && rsp_tready;
   assign cnt_after_pop = cnt_ff - {1'b0, q_pop};
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_after_pop;
      if (q_pop) begin
         q_in[0] = q_ff[1];
      end
      if (res_valid) begin
         q_in[cnt_after_pop[0]] = res;
         cnt_in = cnt_after_pop + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {{(bls_pkg::RSP_TDATA_W - bls_pkg::RSP_BITS){1'b0}}, q_ff[0]};

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the bounded lifo stack unit: push, pop, peek and search
module tb_top;

   localparam int unsigned STACK_DEPTH = 8;
   localparam int unsigned RANDOM_REQS = 600;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] value;
   } stack_request_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic [1:0]  req_tuser;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   // status, data, found, level, empty_res, full_res
   logic [bls_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   stack_request_type pending_reqs[$];
   bls_pkg::rsp_type  expected_rsps[$];

   // shadow copy of the stack contents and fill count
   logic [31:0] shadow_words [STACK_DEPTH];
   int unsigned shadow_fill;

   int unsigned total_reqs;
   int unsigned issued_count;
   int unsigned checked_count;
   int unsigned error_count;
   int unsigned stall_cycles;
   bit          req_taken;
   int unsigned gen_fill;

   bounded_lifo_stack_unit #(.DEPTH(STACK_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock generation
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // apply one operation to the shadow stack and return the response it should give
   function automatic bls_pkg::rsp_type apply_stack_op(logic [1:0] op, logic [31:0] value);
      bls_pkg::rsp_type r;
      r = '0;
      r.status = bls_pkg::ST_OK;
      case (op)
         bls_pkg::OP_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               r.status = bls_pkg::ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = value;
               shadow_fill++;
            end
         end
         bls_pkg::OP_POP, bls_pkg::OP_PEEK: begin
            if (shadow_fill == 0) begin
               r.status = bls_pkg::ST_UNDERFLOW;
            end else begin
               r.data = shadow_words[shadow_fill - 1];
               if (op == bls_pkg::OP_POP) shadow_fill--;
            end
         end
         default: begin
            // key compared against every held entry on all 32 bits
            for (int unsigned k = 0; k < shadow_fill; k++) begin
               if (shadow_words[k] == value) r.found = 1'b1;
            end
         end
      endcase
      r.level     = 4'(shadow_fill);
      r.empty_res = (shadow_fill == 0);
      r.full_res  = (shadow_fill == STACK_DEPTH);
      return r;
   endfunction

   task automatic add_req(logic [1:0] op, logic [31:0] value);
      stack_request_type t;
      t.op = op;
      t.value = value;
      pending_reqs.push_back(t);
   endtask

   // mix of full random words, corner words and small values so searches hit often
   function automatic logic [31:0] pick_word();
      logic [31:0] pool [6];
      int unsigned r;
      pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A};
      r = $urandom_range(99);
      if (r < 40) return $urandom;
      if (r < 70) return pool[$urandom_range(5)];
      return 32'($urandom_range(15));
   endfunction

   task automatic build_requests();
      bit          push_heavy;
      int unsigned r;
      logic [1:0]  op;
      // directed: underflow and search on empty
      add_req(bls_pkg::OP_PEEK, 32'h0000_0000);
      add_req(bls_pkg::OP_POP, 32'hFFFF_FFFF);
      add_req(bls_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      // extremes of the word, then fill to full
      add_req(bls_pkg::OP_PUSH, 32'h8000_0000);
      add_req(bls_pkg::OP_PUSH, 32'h7FFF_FFFF);
      add_req(bls_pkg::OP_PUSH, 32'hFFFF_FFFF);
      add_req(bls_pkg::OP_PUSH, 32'h0000_0000);
      add_req(bls_pkg::OP_SEARCH, 32'h8000_0000);
      add_req(bls_pkg::OP_PUSH, 32'h0000_0001);
      add_req(bls_pkg::OP_PUSH, 32'h0000_0002);
      add_req(bls_pkg::OP_PUSH, 32'h0000_0003);
      add_req(bls_pkg::OP_PUSH, 32'h0000_0004);
      // overflow, then a search for the rejected word must miss
      add_req(bls_pkg::OP_PUSH, 32'h1234_5678);
      add_req(bls_pkg::OP_SEARCH, 32'h1234_5678);
      add_req(bls_pkg::OP_PEEK, 32'h0000_0000);
      add_req(bls_pkg::OP_SEARCH, 32'h0000_0004);
      // drain to empty and underflow once more
      for (int i = 0; i < STACK_DEPTH; i++) add_req(bls_pkg::OP_POP, 32'h0000_0000);
      add_req(bls_pkg::OP_POP, 32'h0000_0000);

      // random: alternate push-heavy and pop-heavy bursts to sweep empty and full
      gen_fill = 0;
      push_heavy = 1'b1;
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (gen_fill >= STACK_DEPTH && $urandom_range(3) == 0) push_heavy = 1'b0;
         if (gen_fill == 0 && $urandom_range(3) == 0) push_heavy = 1'b1;
         if ($urandom_range(19) == 0) push_heavy = ~push_heavy;
         r = $urandom_range(99);
         if (push_heavy) begin
            op = (r < 55) ? bls_pkg::OP_PUSH : (r < 70) ? bls_pkg::OP_POP :
                 (r < 85) ? bls_pkg::OP_PEEK : bls_pkg::OP_SEARCH;
         end else begin
            op = (r < 20) ? bls_pkg::OP_PUSH : (r < 65) ? bls_pkg::OP_POP :
                 (r < 80) ? bls_pkg::OP_PEEK : bls_pkg::OP_SEARCH;
         end
         if (op == bls_pkg::OP_PUSH && gen_fill < STACK_DEPTH) gen_fill++;
         if (op == bls_pkg::OP_POP && gen_fill > 0) gen_fill--;
         add_req(op, pick_word());
      end
      total_reqs = pending_reqs.size();
   endtask

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = bls_pkg::OP_PUSH;
      rsp_tready = 1'b0;
      shadow_fill = 0;
      issued_count = 0;
      checked_count = 0;
      error_count = 0;
      stall_cycles = 0;
      req_taken = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) shadow_words[i] = '0;
      build_requests();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (issued_count < total_reqs) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // driver: request channel and response backpressure, updated on the falling edge
   always @(negedge clock) begin
      stack_request_type nxt;
      bit calm_req;
      bit calm_rsp;
      calm_req = (issued_count >= 250 && issued_count < 400);
      calm_rsp = (checked_count >= 260 && checked_count < 410);
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_reqs.size() != 0 && (calm_req || $urandom_range(99) >= 31)) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.value;
               req_tuser <= nxt.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= calm_rsp || ($urandom_range(99) >= 31);
      end
   end

   // monitor: predict on each request transaction, check each response transaction
   always @(posedge clock) begin
      bls_pkg::rsp_type got;
      bls_pkg::rsp_type want;
      bit      progress;
      progress = 1'b0;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            got = bls_pkg::rsp_type'(rsp_tdata[bls_pkg::RSP_BITS-1:0]);
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               checked_count++;
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.data !== want.data) begin
                  $error("data: expected %h, got %h", want.data, got.data);
                  error_count++;
               end
               if (got.found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, got.found);
                  error_count++;
               end
               if (got.level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, got.level);
                  error_count++;
               end
               if (got.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
                  error_count++;
               end
               if (got.full_res !== want.full_res) begin
                  $error("full_res: expected %0b, got %0b", want.full_res, got.full_res);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            progress = 1'b1;
            req_taken = 1'b1;
            expected_rsps.push_back(apply_stack_op(req_tuser, req_tdata));
            issued_count++;
         end
         // watchdog on cycles without any transaction
         if (progress) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

endmodule
